// ===== rtl/xtae_pkg.sv =====
// Shared types and constants of the XML tag attribute extractor.
`default_nettype none
package xtae_pkg;

  // Longest tag name the matcher compares
  localparam int unsigned MAX_TAG_CHARS = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_CHARS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OCCURRENCE = 2'd2;

  // Special bytes
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'

  // Result kinds
  typedef enum logic [2:0] {
    KIND_NAME_CHAR  = 3'd0,
    KIND_NAME_END   = 3'd1,
    KIND_VALUE_CHAR = 3'd2,
    KIND_VALUE_END  = 3'd3,
    KIND_CLOSED     = 3'd4,
    KIND_NOT_FOUND  = 3'd5,
    KIND_UNTERM     = 3'd6
  } kind_e;

  // Buffer phase, one-hot
  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_PARSE  = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  // Results caused by one item: first result, optional second (always char 0)
  typedef struct packed {
    logic       two;
    kind_e      kind0;
    logic [7:0] char0;
    kind_e      kind1;
  } entry_t;

  // Front to queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Queue head to back
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // Queue fill status
  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } qstat_t;

endpackage
`default_nettype wire

// ===== rtl/xtae_if.sv =====
// Handshake channel interfaces: text bytes, results and configuration writes.
`default_nettype none
interface xtae_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_buffer;
  modport source (output valid, output text_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input text_byte, input end_of_buffer, output ready);
endinterface

interface xtae_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] char_out;
  logic       last_of_run;
  modport source (output valid, output kind, output char_out, output last_of_run, input ready);
  modport sink   (input valid, input kind, input char_out, input last_of_run, output ready);
endinterface

interface xtae_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [xtae_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/xml_tag_attribute_extractor.sv =====
// Path: an accepted item's results are written into the result queue, then loaded into
// the back end's held group register, from which they are offered.
// Throughput: one byte per cycle while the result queue is not full; a byte causing two
// results (end of buffer) has them delivered one after the other.
// The two-entry result queue decouples the byte input from output stalls.
// Reset (async, active low) clears buffer state and queue; registers take
// tag_chars 0, tag_length 0, occurrence 1.
`default_nettype none
module xml_tag_attribute_extractor (
  input  wire          clk_i,
  input  wire          rst_ni,
  xtae_byte_if.sink    byte_i,
  xtae_cfg_if.sink     cfg_i,
  xtae_res_if.source   res_o
);

  xtae_pkg::push_t  push;
  xtae_pkg::head_t  head;
  xtae_pkg::qstat_t qstat;
  logic             pop;

  xtae_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .cfg_i   (cfg_i),
    .qstat_i (qstat),
    .push_o  (push)
  );

  xtae_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  xtae_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

  // No push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !qstat.full)
    else $error("result queue overflow");

  // Pops only from a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (qstat.count != 2'd0))
    else $error("pop from empty result queue");

  // Only character kinds carry a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind != xtae_pkg::KIND_NAME_CHAR &&
     res_o.kind != xtae_pkg::KIND_VALUE_CHAR) |-> (res_o.char_out == 8'd0))
    else $error("nonzero char on non-character result");

  // A delivered non-final result is followed by the rest of its group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !res_o.last_of_run) |=> res_o.valid)
    else $error("result group broken off");

endmodule
`default_nettype wire

// ===== rtl/xtae_front.sv =====
// Front end: configuration registers, tag matcher and attribute classifier.
`default_nettype none
module xtae_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  xtae_byte_if.sink            byte_i,
  xtae_cfg_if.sink             cfg_i,
  input  xtae_pkg::qstat_t     qstat_i,
  output xtae_pkg::push_t      push_o
);

  logic [63:0] tag_chars_q;
  logic [3:0]  tag_length_q;
  logic [7:0]  occurrence_q;

  xtae_pkg::phase_e phase_q, phase_d;
  logic [3:0] match_pos_q, match_pos_d;
  logic [7:0] found_count_q, found_count_d;
  logic       at_start_q, at_start_d;
  logic       in_value_q, in_value_d;
  logic       value_started_q, value_started_d;

  logic             accept;
  logic [7:0]       b;
  logic [3:0]       eff_len;
  logic [3:0]       pat_len;
  logic [2:0]       pat_idx;
  logic [7:0]       pat_byte;
  logic [7:0]       fc_inc;
  logic             do_parse;
  logic             step_emit;
  xtae_pkg::kind_e  step_kind;
  logic [7:0]       step_char;
  logic             eob_emit;
  xtae_pkg::kind_e  eob_kind;

  assign accept       = byte_i.valid && byte_i.ready;
  assign byte_i.ready = !qstat_i.full;
  assign cfg_i.ready  = 1'b1;
  assign b            = byte_i.text_byte;

  // Pattern is '<' then the tag name, length saturated
  assign eff_len  = (tag_length_q > 4'(xtae_pkg::MAX_TAG_CHARS)) ?
                    4'(xtae_pkg::MAX_TAG_CHARS) : tag_length_q;
  assign pat_len  = eff_len + 4'd1;
  assign pat_idx  = 3'(match_pos_q - 4'd1);
  assign pat_byte = tag_chars_q[{pat_idx, 3'b000} +: 8];
  assign fc_inc   = found_count_q + 8'd1;
  assign do_parse = (phase_q == xtae_pkg::PH_PARSE) ||
                    ((phase_q == xtae_pkg::PH_SEARCH) && (occurrence_q == 8'd0));

  // Per-byte decision
  always_comb begin
    phase_d         = phase_q;
    match_pos_d     = match_pos_q;
    found_count_d   = found_count_q;
    at_start_d      = at_start_q;
    in_value_d      = in_value_q;
    value_started_d = value_started_q;
    step_emit       = 1'b0;
    step_kind       = xtae_pkg::KIND_CLOSED;
    step_char       = 8'd0;
    eob_emit        = 1'b0;
    eob_kind        = xtae_pkg::KIND_NOT_FOUND;

    if (do_parse) begin
      // Occurrence zero enters parsing with fresh name mode
      phase_d = xtae_pkg::PH_PARSE;
      if (phase_q == xtae_pkg::PH_SEARCH) begin
        in_value_d      = 1'b0;
        value_started_d = 1'b0;
      end
      if (b == xtae_pkg::CH_GT) begin
        step_emit = 1'b1;
        step_kind = xtae_pkg::KIND_CLOSED;
        phase_d   = xtae_pkg::PH_DONE;
      end else if (b == xtae_pkg::CH_SPACE || b == xtae_pkg::CH_SLASH) begin
        step_emit = 1'b0;
      end else if (!in_value_d) begin
        step_emit = 1'b1;
        if (b == xtae_pkg::CH_EQ) begin
          step_kind       = xtae_pkg::KIND_NAME_END;
          in_value_d      = 1'b1;
          value_started_d = 1'b0;
        end else begin
          step_kind = xtae_pkg::KIND_NAME_CHAR;
          step_char = b;
        end
      end else if (b == xtae_pkg::CH_QUOTE) begin
        if (value_started_d) begin
          step_emit       = 1'b1;
          step_kind       = xtae_pkg::KIND_VALUE_END;
          in_value_d      = 1'b0;
          value_started_d = 1'b0;
        end
      end else begin
        step_emit       = 1'b1;
        step_kind       = xtae_pkg::KIND_VALUE_CHAR;
        step_char       = b;
        value_started_d = 1'b1;
      end
    end else if (phase_q == xtae_pkg::PH_SEARCH) begin
      // Matcher; a mismatch rechecks the byte as a new '<'
      if (match_pos_q != 4'd0 && match_pos_q < pat_len && b == pat_byte) begin
        match_pos_d = match_pos_q + 4'd1;
      end else if (b == xtae_pkg::CH_LT) begin
        at_start_d  = (match_pos_q == 4'd0) && at_start_q;
        match_pos_d = 4'd1;
      end else begin
        match_pos_d = 4'd0;
        at_start_d  = 1'b0;
      end
      if (match_pos_d != 4'd0 && match_pos_d >= pat_len) begin
        match_pos_d = 4'd0;
        if (at_start_d) begin
          // Match at buffer start counts as not found
          at_start_d = 1'b0;
          step_emit  = 1'b1;
          step_kind  = xtae_pkg::KIND_NOT_FOUND;
          phase_d    = xtae_pkg::PH_DONE;
        end else begin
          found_count_d = fc_inc;
          if (fc_inc == occurrence_q) begin
            phase_d         = xtae_pkg::PH_PARSE;
            in_value_d      = 1'b0;
            value_started_d = 1'b0;
          end
        end
      end
    end

    // End of buffer reports and clears buffer state
    if (byte_i.end_of_buffer) begin
      eob_emit        = (phase_d != xtae_pkg::PH_DONE);
      eob_kind        = (phase_d == xtae_pkg::PH_SEARCH) ?
                        xtae_pkg::KIND_NOT_FOUND : xtae_pkg::KIND_UNTERM;
      phase_d         = xtae_pkg::PH_SEARCH;
      match_pos_d     = 4'd0;
      found_count_d   = 8'd0;
      at_start_d      = 1'b1;
      in_value_d      = 1'b0;
      value_started_d = 1'b0;
    end else begin
      at_start_d = at_start_d && (match_pos_d != 4'd0);
    end
  end

  // Pack results into one queue entry
  always_comb begin
    push_o.valid = accept && (step_emit || eob_emit);
    if (step_emit) begin
      push_o.entry.two   = eob_emit;
      push_o.entry.kind0 = step_kind;
      push_o.entry.char0 = step_char;
    end else begin
      push_o.entry.two   = 1'b0;
      push_o.entry.kind0 = eob_kind;
      push_o.entry.char0 = 8'd0;
    end
    push_o.entry.kind1 = eob_kind;
  end

  // Buffer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= xtae_pkg::PH_SEARCH;
      match_pos_q     <= 4'd0;
      found_count_q   <= 8'd0;
      at_start_q      <= 1'b1;
      in_value_q      <= 1'b0;
      value_started_q <= 1'b0;
    end else if (accept) begin
      phase_q         <= phase_d;
      match_pos_q     <= match_pos_d;
      found_count_q   <= found_count_d;
      at_start_q      <= at_start_d;
      in_value_q      <= in_value_d;
      value_started_q <= value_started_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_chars_q  <= 64'd0;
      tag_length_q <= 4'd0;
      occurrence_q <= 8'd1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        xtae_pkg::CFG_TAG_CHARS:  tag_chars_q  <= cfg_i.data;
        xtae_pkg::CFG_TAG_LENGTH: tag_length_q <= cfg_i.data[3:0];
        xtae_pkg::CFG_OCCURRENCE: occurrence_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xtae_queue.sv =====
// Two-entry queue of result groups between front and back.
`default_nettype none
module xtae_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  xtae_pkg::push_t     push_i,
  input  wire                 pop_i,
  output xtae_pkg::head_t     head_o,
  output xtae_pkg::qstat_t    qstat_o
);

  xtae_pkg::entry_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign do_push = push_i.valid && (count_q != 2'd2);
  assign do_pop  = pop_i && (count_q != 2'd0);

  assign head_o.valid  = (count_q != 2'd0);
  assign head_o.entry  = mem_q[rd_ptr_q];
  assign qstat_o.full  = (count_q == 2'd2);
  assign qstat_o.count = count_q;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xtae_back.sv =====
// Back end: holds one result group and delivers its results one at a time.
`default_nettype none
module xtae_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  xtae_pkg::head_t     head_i,
  output logic                pop_o,
  xtae_res_if.source          res_o
);

  xtae_pkg::entry_t cur_q;
  logic cur_valid_q, cur_valid_d;
  logic sel_q, sel_d;
  logic fire;
  logic last;
  logic load;

  assign last  = !cur_q.two || sel_q;
  assign fire  = res_o.valid && res_o.ready;
  assign load  = !cur_valid_q || (fire && last);
  assign pop_o = load && head_i.valid;

  // Output from the held group
  assign res_o.valid       = cur_valid_q;
  assign res_o.kind        = sel_q ? cur_q.kind1 : cur_q.kind0;
  assign res_o.char_out    = sel_q ? 8'd0 : cur_q.char0;
  assign res_o.last_of_run = last;

  always_comb begin
    cur_valid_d = cur_valid_q;
    sel_d       = sel_q;
    if (load) begin
      cur_valid_d = head_i.valid;
      sel_d       = 1'b0;
    end else if (fire) begin
      sel_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      sel_q       <= sel_d;
    end
  end

endmodule
`default_nettype wire

// ===== bench/xtae_tb_pkg.sv =====
// Attribute stream predictor and result checker for the tag attribute extractor bench.
package xtae_tb_pkg;
  import xtae_pkg::*;

  // One expected result
  typedef struct {
    kind_e      kind;
    logic [7:0] ch;
    logic       last;
  } attr_item_t;

  class attr_extract_sb;
    // Register copies
    logic [63:0] tag_chars;
    logic [3:0]  tag_length;
    logic [7:0]  occurrence;
    // Per-buffer state
    phase_e      phase;
    logic [3:0]  match_pos;
    logic [7:0]  found_count;
    bit          at_start;
    bit          in_value;
    bit          value_started;
    // Results still owed by the block
    attr_item_t  expected_attrs[$];
    int unsigned errors;

    function new();
      tag_chars  = '0;
      tag_length = '0;
      occurrence = 8'd1;
      errors     = 0;
      clear_buffer();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_TAG_CHARS:  tag_chars  = data;
        CFG_TAG_LENGTH: tag_length = data[3:0];
        CFG_OCCURRENCE: occurrence = data[7:0];
        default: ;
      endcase
    endfunction

    function void clear_buffer();
      phase         = PH_SEARCH;
      match_pos     = '0;
      found_count   = '0;
      at_start      = 1'b1;
      in_value      = 1'b0;
      value_started = 1'b0;
    endfunction

    function void emit(kind_e k, logic [7:0] c);
      attr_item_t r;
      r.kind = k;
      r.ch   = c;
      r.last = 1'b0;
      expected_attrs.push_back(r);
    endfunction

    // Byte of the search pattern: '<' then the tag name
    function logic [7:0] tag_byte(int unsigned pos);
      return (pos == 0) ? CH_LT : tag_chars[8*(pos-1) +: 8];
    endfunction

    // Attribute stream: '>' closes, space and slash dropped
    function void parse_attr(logic [7:0] b);
      if (b == CH_GT) begin
        emit(KIND_CLOSED, 8'h00);
        phase = PH_DONE;
      end else if (b != CH_SPACE && b != CH_SLASH) begin
        if (!in_value) begin
          if (b == CH_EQ) begin
            emit(KIND_NAME_END, 8'h00);
            in_value      = 1'b1;
            value_started = 1'b0;
          end else begin
            emit(KIND_NAME_CHAR, b);
          end
        end else if (b == CH_QUOTE) begin
          // opening quote skipped, a later one ends the value
          if (value_started) begin
            emit(KIND_VALUE_END, 8'h00);
            in_value      = 1'b0;
            value_started = 1'b0;
          end
        end else begin
          emit(KIND_VALUE_CHAR, b);
          value_started = 1'b1;
        end
      end
    endfunction

    // Tag search; a mismatch rechecks the byte as a new '<'
    function void search_tag(logic [7:0] b);
      int unsigned plen;
      plen = ((tag_length > MAX_TAG_CHARS) ? MAX_TAG_CHARS : tag_length) + 1;
      if (match_pos != 0 && match_pos < plen && b == tag_byte(match_pos)) begin
        match_pos++;
      end else if (b == CH_LT) begin
        at_start  = (match_pos == 0) && at_start;
        match_pos = 4'd1;
      end else begin
        match_pos = '0;
        at_start  = 1'b0;
        return;
      end
      if (match_pos < plen) return;
      match_pos = '0;
      // full match at buffer offset zero counts as not found
      if (at_start) begin
        at_start = 1'b0;
        emit(KIND_NOT_FOUND, 8'h00);
        phase = PH_DONE;
        return;
      end
      found_count++;
      if (found_count == occurrence) begin
        phase         = PH_PARSE;
        in_value      = 1'b0;
        value_started = 1'b0;
      end
    endfunction

    // Accepted text byte: queue the results it causes
    function void predict_byte(logic [7:0] b, logic eob);
      int unsigned queued;
      attr_item_t  tail;
      queued = expected_attrs.size();
      case (phase)
        PH_SEARCH: begin
          if (occurrence == 0) begin
            phase         = PH_PARSE;
            in_value      = 1'b0;
            value_started = 1'b0;
            parse_attr(b);
          end else begin
            search_tag(b);
          end
        end
        PH_PARSE: parse_attr(b);
        default: ;
      endcase
      if (eob) begin
        if (phase == PH_SEARCH) emit(KIND_NOT_FOUND, 8'h00);
        else if (phase == PH_PARSE) emit(KIND_UNTERM, 8'h00);
        clear_buffer();
      end else begin
        at_start = at_start && (match_pos != 0);
      end
      if (expected_attrs.size() > queued) begin
        tail = expected_attrs.pop_back();
        tail.last = 1'b1;
        expected_attrs.push_back(tail);
      end
    endfunction

    function void note_mismatch(longint unsigned now, string field,
                                logic [7:0] exp_v, logic [7:0] act_v);
      errors++;
      $display("[%0d ns] %s mismatch: expected %h, got %h", now, field, exp_v, act_v);
    endfunction

    // Accepted result against the oldest expectation
    function void check_result(longint unsigned now, logic [2:0] kind, logic [7:0] ch,
                               logic last);
      attr_item_t exp_r;
      if (expected_attrs.size() == 0) begin
        errors++;
        $display("[%0d ns] result with nothing expected: expected none, got kind %0d char %h",
                 now, kind, ch);
        return;
      end
      exp_r = expected_attrs.pop_front();
      if (kind !== exp_r.kind) note_mismatch(now, "kind", 8'(exp_r.kind), 8'(kind));
      if (ch !== exp_r.ch) note_mismatch(now, "char_out", exp_r.ch, ch);
      if (last !== exp_r.last)
        note_mismatch(now, "last_of_run", 8'(exp_r.last), 8'(last));
    endfunction
  endclass

endpackage

// ===== bench/tb_xml_tag_attribute_extractor.sv =====
// Top-level bench: drives text buffers and register settings, checks the attribute stream.
module tb_xml_tag_attribute_extractor;
  timeunit 1ns;
  timeprecision 1ps;
  import xtae_pkg::*;
  import xtae_tb_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 9;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    logic [7:0] b;
    logic       eob;
  } text_item_t;

  logic clk = 1'b0;
  logic rst_n;

  xtae_byte_if byte_if();
  xtae_res_if  res_if();
  xtae_cfg_if  cfg_if();

  xml_tag_attribute_extractor u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  attr_extract_sb sb;
  text_item_t     stim_q[$];
  logic [63:0]    gen_tag_chars;
  logic [3:0]     gen_tag_len;
  logic [7:0]     gen_occ;
  bit             send_calm;
  bit             recv_calm;
  int             recv_hold;
  int             idle_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor: note accepted bytes and register writes, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (byte_if.valid && byte_if.ready) sb.predict_byte(byte_if.text_byte, byte_if.end_of_buffer);
      if (res_if.valid && res_if.ready)
        sb.check_result($time, res_if.kind, res_if.char_out, res_if.last_of_run);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, one long hold on request
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (recv_hold > 0) begin
        res_if.ready <= 1'b0;
        repeat (recv_hold) @(posedge clk);
        recv_hold = 0;
      end
      stall = recv_calm ? 0 : $urandom_range(5);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // ---- stimulus building ----

  function automatic logic [7:0] rand_text_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] rand_byte_except_lt();
    logic [7:0] b;
    do b = rand_text_byte(); while (b == CH_LT);
    return b;
  endfunction

  function automatic logic [7:0] letter();
    return 8'(8'h61 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] special_byte();
    case ($urandom_range(5))
      0: return CH_LT;
      1: return CH_GT;
      2: return CH_EQ;
      3: return CH_QUOTE;
      4: return CH_SPACE;
      default: return CH_SLASH;
    endcase
  endfunction

  // Mostly letters, sometimes any byte but the terminator and '>'
  function automatic logic [7:0] attr_byte(logic [7:0] stop);
    logic [7:0] b;
    if ($urandom_range(3) != 0) return letter();
    do b = rand_text_byte(); while (b == stop || b == CH_GT);
    return b;
  endfunction

  function automatic logic [63:0] rand_tag_chars(int eff);
    logic [63:0] c;
    c = {$urandom, $urandom};
    for (int i = 0; i < eff && i < 8; i++) c[8*i +: 8] = letter();
    return c;
  endfunction

  // Text bytes are nonzero
  task automatic add_byte(logic [7:0] b);
    text_item_t t;
    t.b   = (b == 8'h00) ? 8'h01 : b;
    t.eob = 1'b0;
    stim_q.push_back(t);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic close_buffer();
    text_item_t t;
    t = stim_q.pop_back();
    t.eob = 1'b1;
    stim_q.push_back(t);
  endtask

  // Sometimes cut the buffer short, then mark its last byte
  task automatic finish_buffer(int start);
    int drop;
    if (stim_q.size() == start) add_byte(rand_text_byte());
    if ($urandom_range(5) == 0) begin
      drop = $urandom_range(stim_q.size() - start - 1);
      repeat (drop) void'(stim_q.pop_back());
    end
    close_buffer();
  endtask

  task automatic add_tag(int eff);
    add_byte(CH_LT);
    for (int i = 0; i < eff; i++) add_byte(gen_tag_chars[8*i +: 8]);
  endtask

  // '<' and a proper prefix of the name, broken off before the match completes
  task automatic add_partial(int eff);
    int k;
    k = $urandom_range(eff - 1);
    add_byte(CH_LT);
    for (int i = 0; i < k; i++) add_byte(gen_tag_chars[8*i +: 8]);
  endtask

  task automatic add_attrs();
    repeat ($urandom_range(3)) begin
      if ($urandom_range(1)) add_byte(CH_SPACE);
      repeat ($urandom_range(1, 4)) add_byte(attr_byte(CH_EQ));
      add_byte(CH_EQ);
      if ($urandom_range(7) != 0) add_byte(CH_QUOTE);
      repeat ($urandom_range(1, 5)) add_byte(attr_byte(CH_QUOTE));
      add_byte(CH_QUOTE);
    end
  endtask

  task automatic add_close();
    if ($urandom_range(3) == 0) add_byte(CH_SLASH);
    add_byte(CH_GT);
  endtask

  // Buffer holding around the wanted number of tags with attributes
  task automatic build_good_buffer();
    int start;
    int eff;
    int tags;
    start = stim_q.size();
    eff = (gen_tag_len > MAX_TAG_CHARS) ? MAX_TAG_CHARS : gen_tag_len;
    if (gen_occ == 0) begin
      add_attrs();
      add_close();
    end else begin
      // no prefix now and then: the first tag starts at offset zero
      if ($urandom_range(9) != 0) repeat ($urandom_range(1, 4)) add_byte(rand_byte_except_lt());
      tags = gen_occ + $urandom_range(2) - 1;
      repeat (tags) begin
        if (eff > 0 && $urandom_range(3) == 0) add_partial(eff);
        add_tag(eff);
        add_attrs();
        if ($urandom_range(5) != 0) add_close();
        repeat ($urandom_range(2)) add_byte(rand_byte_except_lt());
      end
    end
    repeat ($urandom_range(3)) add_byte(rand_text_byte());
    finish_buffer(start);
  endtask

  task automatic build_noise_buffer();
    int start;
    start = stim_q.size();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(3))
        0: add_byte(special_byte());
        1: add_byte(gen_tag_chars[8*$urandom_range(7) +: 8]);
        default: add_byte(rand_text_byte());
      endcase
    end
    finish_buffer(start);
  endtask

  // Around 255 bare '<' matches for the highest occurrence setting
  task automatic build_lt_run();
    add_byte(rand_byte_except_lt());
    repeat (254 + $urandom_range(2)) begin
      add_byte(CH_LT);
      if ($urandom_range(3) == 0) add_byte(rand_byte_except_lt());
    end
    add_attrs();
    add_close();
    close_buffer();
  endtask

  // ---- driving ----

  task automatic send_item(text_item_t t);
    int gap;
    gap = send_calm ? 0 : $urandom_range(5);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_if.valid         <= 1'b1;
    byte_if.text_byte     <= t.b;
    byte_if.end_of_buffer <= t.eob;
    do @(posedge clk); while (!byte_if.ready);
  endtask

  task automatic send_all();
    foreach (stim_q[i]) send_item(stim_q[i]);
    byte_if.valid <= 1'b0;
    stim_q.delete();
  endtask

  task automatic cfg_send(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic write_config(logic [63:0] chars, logic [3:0] len, logic [7:0] occ);
    gen_tag_chars = chars;
    gen_tag_len   = len;
    gen_occ       = occ;
    cfg_send(CFG_TAG_CHARS, chars);
    cfg_send(CFG_TAG_LENGTH, {60'h0, len});
    cfg_send(CFG_OCCURRENCE, {56'h0, occ});
    cfg_if.valid <= 1'b0;
  endtask

  // Wait for every owed result, then let the pipeline settle
  task automatic wait_idle();
    @(posedge clk);
    while (sb.expected_attrs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---- main sequence ----
  initial begin
    logic [63:0] chars;
    logic [3:0]  len;
    logic [7:0]  occ;
    sb = new();
    recv_hold = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    gen_tag_chars = '0;
    gen_tag_len   = '0;
    gen_occ       = 8'd1;
    rst_n <= 1'b0;
    byte_if.valid         <= 1'b0;
    byte_if.text_byte     <= 8'h00;
    byte_if.end_of_buffer <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_TAG_CHARS;
    cfg_if.data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers, pattern is a bare '<': match at offset zero, parse, run-offs
    add_byte(CH_LT);
    add_byte(8'hFF);
    add_byte(CH_GT);
    close_buffer();
    add_text(" <a=\"b\">");
    close_buffer();
    add_byte(8'h01);
    add_text("<c");
    close_buffer();
    add_text("q");
    close_buffer();
    send_all();
    wait_idle();

    // Tag "ab", second occurrence, with a broken match rechecked on '<'
    write_config(64'h6261, 4'd2, 8'd2);
    add_byte(8'hFF);
    add_text("<a<ab<ab/>");
    close_buffer();
    send_all();
    wait_idle();

    // Random phases, one register setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          len = 4'($urandom_range(1, 8));
          occ = 8'd1;
          chars = rand_tag_chars(int'(len));
        end
        1: begin
          len = 4'd3;
          occ = 8'($urandom_range(2, 3));
          chars = rand_tag_chars(3);
        end
        2: begin
          len = 4'd8;
          occ = 8'd1;
          chars = rand_tag_chars(8);
        end
        3: begin
          len = 4'($urandom_range(9, 15));
          occ = 8'($urandom_range(1, 2));
          chars = rand_tag_chars(8);
        end
        4: begin
          len = 4'd0;
          occ = 8'd1;
          chars = {$urandom, $urandom};
        end
        5: begin
          len = 4'($urandom_range(1, 8));
          occ = 8'd0;
          chars = rand_tag_chars(int'(len));
        end
        6: begin
          len = 4'd15;
          occ = 8'($urandom_range(1, 3));
          chars = '1;
        end
        7: begin
          len = 4'd0;
          occ = 8'd255;
          chars = {$urandom, $urandom};
        end
        default: begin
          len = 4'($urandom_range(1, 8));
          occ = 8'd2;
          chars = '0;
        end
      endcase
      write_config(chars, len, occ);
      send_calm = (ph == 1) || (ph == 5);
      recv_calm = (ph == 4) || (ph == 5);
      // long receiver hold while bytes keep coming
      if (ph == 1) recv_hold = 60;
      if (gen_occ > 3) build_lt_run();
      while (stim_q.size() < PHASE_ITEMS) begin
        if ($urandom_range(4) == 0) build_noise_buffer();
        else build_good_buffer();
      end
      send_all();
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/xtae_pkg.sv
rtl/xtae_if.sv
rtl/xtae_front.sv
rtl/xtae_queue.sv
rtl/xtae_back.sv
rtl/xml_tag_attribute_extractor.sv
bench/xtae_tb_pkg.sv
bench/tb_xml_tag_attribute_extractor.sv
